### sv/kslack_reorder_buffer_top_defines.svh
// Assertion macros shared by the reorder buffer RTL.
`ifndef KSLACK_REORDER_BUFFER_TOP_DEFINES_SVH
`define KSLACK_REORDER_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define KSRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define KSRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ksrb_pkg.sv
package ksrb_pkg;

  // Default number of buffered tuples.
  localparam int unsigned CAPACITY_DEF = 32;

  // Reset value of the slack period register.
  localparam logic [15:0] PERIOD_RST = 16'd100;

  // Byte address of the slack period register.
  localparam logic [1:0] ADDR_SLACK_PERIOD = 2'd0;

  // One buffered tuple.
  typedef struct packed {
    logic [31:0] delay;
    logic [31:0] tag;
    logic [31:0] etime;
  } entry_t;

endpackage

### sv/kslack_reorder_buffer_top.sv
// Channel  Dir  Transfer        Payload
// s_axis   in   tvalid & tready tdata: event_time, tuple_tag, new_slack; tlast: is_end
// m_axis   out  tvalid & tready tdata: out_time, out_tag, out_delay; tuser: forced; tlast: last
// apb      in   access phase    slack_period at byte address 0
//
// An arrival passes an accept step and the bit-serial modulo unit. Each release decision then
// scans all n buffered tuples; a release adds a take step and closes the gap after entry i.
// Storing and finishing follow as separate steps. An end item skips the modulo step and the store.
// Reset is asynchronous and active low; the buffer comes up empty with no clearing pass.
// A stalled output holds the sequencer whenever a held release needs the output register.
`include "kslack_reorder_buffer_top_defines.svh"

module kslack_reorder_buffer_top #(
  parameter int unsigned CAPACITY = ksrb_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] event_time, [63:32] tuple_tag, [79:64] new_slack
  input  logic [79:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] out_time, [63:32] out_tag, [95:64] out_delay
  output logic [95:0] m_axis_tdata_o,
  // [0] forced
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIV    = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_TAKE   = 7'b0001000,
    ST_SHIFT  = 7'b0010000,
    ST_STORE  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q;

  logic [15:0]     period_q;
  logic [31:0]     clock_q;
  logic [15:0]     slack_q;
  logic [CW-1:0]   cnt_q;
  logic            in_end_q;
  logic [31:0]     in_time_q;
  logic [31:0]     in_tag_q;
  logic [15:0]     in_ns_q;
  logic [31:0]     delay_q;
  logic [15:0]     rem_q;
  logic [4:0]      div_cnt_q;
  logic [CW-1:0]   sc_q;
  logic            rd_vld_q;
  logic [CW-1:0]   rd_idx_q;
  ksrb_pkg::entry_t rd_data_q;
  logic            best_vld_q;
  logic [CW-1:0]   best_idx_q;
  ksrb_pkg::entry_t best_q;
  logic            forced_q;
  logic            hold_vld_q;
  logic            hold_forced_q;
  ksrb_pkg::entry_t hold_q;
  logic            out_vld_q;
  logic            out_forced_q;
  logic            out_last_q;
  ksrb_pkg::entry_t out_q;

  ksrb_pkg::entry_t mem [CAPACITY];

  logic            rd_en;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  ksrb_pkg::entry_t wr_data;
  logic            scan_done;
  logic            fits;
  logic            out_free;
  logic            in_xfer;
  logic            cfg_wr;
  logic [16:0]     div_shift;
  logic [16:0]     div_diff;
  logic [15:0]     rem_next;
  logic [CW-1:0]   cnt_dec;

  // Handshakes and the configuration port.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign pready_o        = 1'b1;
  assign cfg_wr          = psel_i && penable_i && pwrite_i &&
                           (paddr_i == ksrb_pkg::ADDR_SLACK_PERIOD);
  assign prdata_o        = (paddr_i == ksrb_pkg::ADDR_SLACK_PERIOD) ?
                           {16'd0, period_q} : 32'd0;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_q.delay, out_q.tag, out_q.etime};
  assign m_axis_tuser_o  = out_forced_q;
  assign m_axis_tlast_o  = out_last_q;

  // One restoring step of the clock modulo period.
  assign div_shift = {rem_q, clock_q[div_cnt_q]};
  assign div_diff  = div_shift - {1'b0, period_q};
  assign rem_next  = (div_shift >= {1'b0, period_q}) ? div_diff[15:0] : div_shift[15:0];

  // Memory port control for scanning and gap closing.
  assign rd_en     = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (sc_q < cnt_q);
  assign scan_done = !rd_en && !rd_vld_q;
  assign fits      = ({1'b0, best_q.etime} + {17'd0, slack_q}) <= {1'b0, clock_q};
  assign cnt_dec   = cnt_q - 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q[IW-1:0];
    wr_data = '{delay: delay_q, tag: in_tag_q, etime: in_time_q};
    if (state_q == ST_SHIFT && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = cnt_dec[IW-1:0] - (cnt_dec[IW-1:0] - rd_idx_q[IW-1:0]) - 1'b1;
      wr_data = rd_data_q;
    end else if (state_q == ST_STORE) begin
      wr_en = 1'b1;
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[sc_q[IW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_time_q <= s_axis_tdata_i[31:0];
      in_tag_q  <= s_axis_tdata_i[63:32];
      in_ns_q   <= s_axis_tdata_i[79:64];
    end
    if (state_q == ST_DIV) begin
      delay_q <= clock_q - in_time_q;
    end
    rd_idx_q <= sc_q;
    if (rd_vld_q && (state_q == ST_SCAN) &&
        (!best_vld_q || rd_data_q.etime < best_q.etime)) begin
      best_q     <= rd_data_q;
      best_idx_q <= rd_idx_q;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      period_q      <= ksrb_pkg::PERIOD_RST;
      clock_q       <= '0;
      slack_q       <= '0;
      cnt_q         <= '0;
      in_end_q      <= 1'b0;
      rem_q         <= '0;
      div_cnt_q     <= '0;
      sc_q          <= '0;
      rd_vld_q      <= 1'b0;
      best_vld_q    <= 1'b0;
      forced_q      <= 1'b0;
      hold_vld_q    <= 1'b0;
      hold_forced_q <= 1'b0;
      hold_q        <= '0;
      out_vld_q     <= 1'b0;
      out_forced_q  <= 1'b0;
      out_last_q    <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cfg_wr) begin
        period_q <= pwdata_i[15:0];
      end
      if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      rd_vld_q <= rd_en;
      if (rd_en) begin
        sc_q <= sc_q + 1'b1;
      end
      if (rd_vld_q && (state_q == ST_SCAN) &&
          (!best_vld_q || rd_data_q.etime < best_q.etime)) begin
        best_vld_q <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            in_end_q   <= s_axis_tlast_i;
            sc_q       <= '0;
            best_vld_q <= 1'b0;
            forced_q   <= 1'b0;
            if (s_axis_tlast_i) begin
              state_q <= ST_SCAN;
            end else begin
              if (s_axis_tdata_i[31:0] > clock_q) begin
                clock_q <= s_axis_tdata_i[31:0];
              end
              rem_q     <= '0;
              div_cnt_q <= 5'd31;
              state_q   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q     <= rem_next;
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == 5'd0) begin
            if (clock_q != 32'd0 && period_q != 16'd0 && rem_next == 16'd0) begin
              slack_q <= in_ns_q;
            end
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (!best_vld_q) begin
              state_q <= in_end_q ? ST_FINISH : ST_STORE;
            end else if (in_end_q || fits) begin
              forced_q <= 1'b0;
              state_q  <= ST_TAKE;
            end else if (cnt_q >= CW'(CAPACITY)) begin
              forced_q <= 1'b1;
              state_q  <= ST_TAKE;
            end else begin
              state_q <= ST_STORE;
            end
          end
        end
        ST_TAKE: begin
          // The held result leaves once the next release is known.
          if (!hold_vld_q || out_free) begin
            if (hold_vld_q) begin
              out_q        <= hold_q;
              out_forced_q <= hold_forced_q;
              out_last_q   <= 1'b0;
              out_vld_q    <= 1'b1;
            end
            hold_q        <= best_q;
            hold_forced_q <= forced_q;
            hold_vld_q    <= 1'b1;
            sc_q          <= best_idx_q + 1'b1;
            state_q       <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (scan_done) begin
            cnt_q      <= cnt_dec;
            sc_q       <= '0;
            best_vld_q <= 1'b0;
            state_q    <= forced_q ? ST_STORE : ST_SCAN;
          end
        end
        ST_STORE: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!hold_vld_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_q        <= hold_q;
            out_forced_q <= hold_forced_q;
            out_last_q   <= 1'b1;
            out_vld_q    <= 1'b1;
            hold_vld_q   <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the capacity.
  `KSRB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY), "fill count above capacity")
  // No release may be left behind when the next item is taken.
  `KSRB_ASSERT_IMP(a_idle_hold, state_q == ST_IDLE, !hold_vld_q, "held result in idle")
  // Storing a tuple grows the buffer by one.
  `KSRB_ASSERT_NXT(a_store_inc, state_q == ST_STORE, cnt_q == $past(cnt_q) + 1'b1,
                   "store did not grow the buffer")
  // Closing a gap only happens on a nonempty buffer.
  `KSRB_ASSERT_IMP(a_shift_nonempty, state_q == ST_SHIFT, cnt_q != '0,
                   "removal from an empty buffer")

endmodule
